[rtl/lnp_pkg.sv]
package lnp_pkg;

  // Opcode bytes of the line program.
  localparam logic [7:0] OP_EXTENDED     = 8'd0;
  localparam logic [7:0] OP_COPY         = 8'd1;
  localparam logic [7:0] OP_ADVANCE_PC   = 8'd2;
  localparam logic [7:0] OP_ADVANCE_LINE = 8'd3;
  localparam logic [7:0] OP_SET_FILE     = 8'd4;
  localparam logic [7:0] OP_SET_COLUMN   = 8'd5;
  localparam logic [7:0] OP_NEGATE_STMT  = 8'd6;
  localparam logic [7:0] OP_SET_BB       = 8'd7;
  localparam logic [7:0] OP_CONST_ADD_PC = 8'd8;
  localparam logic [7:0] OP_FIXED_ADV_PC = 8'd9;
  localparam logic [7:0] OP_SET_PROLOGUE = 8'd10;
  localparam logic [7:0] OP_SET_EPILOGUE = 8'd11;
  localparam logic [7:0] OP_SET_ISA      = 8'd12;
  localparam logic [7:0] OP_LAST_STD     = 8'd12;
  localparam logic [7:0] OP_MAX_SPECIAL  = 8'd255;

  // Extended sub-opcodes.
  localparam logic [7:0] EXT_END_SEQ     = 8'd1;
  localparam logic [7:0] EXT_SET_ADDRESS = 8'd2;
  localparam logic [7:0] EXT_DISCRIM     = 8'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_OP_BASE      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LN_RANGE     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LN_BASE      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_INSN_LEN = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_STMT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_FILE_COUNT   = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration values after reset.
  localparam logic [3:0]  RST_OP_BASE      = 4'd13;
  localparam logic [7:0]  RST_LN_RANGE     = 8'd14;
  localparam logic [7:0]  RST_LN_BASE      = 8'hFB;
  localparam logic [7:0]  RST_MIN_INSN_LEN = 8'd1;
  localparam logic        RST_DEFAULT_STMT = 1'b1;
  localparam logic [15:0] RST_FILE_COUNT   = 16'd2;

  localparam int unsigned MAX_ADDR_BITS = 64;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNKNOWN   = 2'd1,
    ERR_UNDERFLOW = 2'd2
  } err_e;

  // What the back end does with a queued word.
  typedef enum logic [3:0] {
    K_NOP,
    K_COPY,
    K_ADV_ADDR,
    K_ADV_LINE,
    K_SET_FILE,
    K_NEG_STMT,
    K_SPECIAL,
    K_END_SEQ,
    K_SET_ADDR,
    K_BAD_OP
  } kind_e;

  typedef struct packed {
    logic [3:0]        op_base;
    logic [7:0]        ln_range;
    logic signed [7:0] ln_base;
    logic [7:0]        min_insn_len;
    logic              default_stmt;
    logic [15:0]       file_count;
  } cfg_t;

  // addr_val is an address increment or a new address, depending on kind.
  typedef struct packed {
    kind_e                    kind;
    logic [MAX_ADDR_BITS-1:0] addr_val;
    logic [31:0]              file;
    logic signed [31:0]       ldelta;
  } entry_t;

endpackage

[rtl/lnp_front.sv]
module lnp_front import lnp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  cmd_i,
  input  logic [7:0]  ext_op_i,
  input  logic [63:0] operand_i,
  input  logic [31:0] ln_adv_i,
  output logic        push_o,
  input  logic        push_ready_i,
  output entry_t      entry_o
);

  typedef enum logic {F_IDLE, F_DIV} state_e;

  localparam int unsigned STEPS_PER_CYCLE = 4;

  state_e     state_q;
  logic       step_q;
  logic       pend_q;
  entry_t     ent_q;
  logic [7:0] rem_q, quo_q, div_q;

  entry_t      ent_c;
  logic        need_div;
  logic [7:0]  adj_c, div_c;
  logic [7:0]  rem_d, quo_d;
  logic [15:0] prod;
  logic        accept;

  assign push_o     = pend_q;
  assign entry_o    = ent_q;
  assign in_ready_o = (state_q == F_IDLE) && (!pend_q || push_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign div_c      = (cfg_i.ln_range == 8'd0) ? 8'd1 : cfg_i.ln_range;

  always_comb begin
    ent_c.kind     = K_NOP;
    ent_c.addr_val = operand_i;
    ent_c.file     = operand_i[31:0];
    ent_c.ldelta   = $signed(ln_adv_i);
    need_div       = 1'b0;
    adj_c          = cmd_i - {4'b0, cfg_i.op_base};
    priority if (cmd_i == OP_EXTENDED) begin
      unique case (ext_op_i)
        EXT_END_SEQ:     ent_c.kind = K_END_SEQ;
        EXT_SET_ADDRESS: ent_c.kind = K_SET_ADDR;
        EXT_DISCRIM:     ent_c.kind = K_NOP;
        default:         ent_c.kind = K_BAD_OP;
      endcase
    end else if (cmd_i <= OP_LAST_STD) begin
      // Opcodes that only touch flags which never appear in a row are no-ops here.
      unique case (cmd_i)
        OP_COPY: ent_c.kind = K_COPY;
        OP_ADVANCE_PC: begin
          ent_c.kind     = K_ADV_ADDR;
          ent_c.addr_val = operand_i * {56'b0, cfg_i.min_insn_len};
        end
        OP_ADVANCE_LINE: ent_c.kind = K_ADV_LINE;
        OP_SET_FILE:     ent_c.kind = K_SET_FILE;
        OP_NEGATE_STMT:  ent_c.kind = K_NEG_STMT;
        OP_CONST_ADD_PC: begin
          ent_c.kind = K_ADV_ADDR;
          need_div   = 1'b1;
          adj_c      = OP_MAX_SPECIAL - {4'b0, cfg_i.op_base};
        end
        OP_FIXED_ADV_PC: begin
          ent_c.kind     = K_ADV_ADDR;
          ent_c.addr_val = {48'b0, operand_i[15:0]};
        end
        OP_SET_COLUMN, OP_SET_BB, OP_SET_PROLOGUE, OP_SET_EPILOGUE, OP_SET_ISA:
          ent_c.kind = K_NOP;
        default: ent_c.kind = K_NOP;
      endcase
    end else begin
      ent_c.kind = K_SPECIAL;
      need_div   = 1'b1;
    end
  end

  // Restoring divider, four quotient bits per cycle. The dividend shifts out
  // of quo_q from the top while quotient bits enter from the bottom.
  always_comb begin
    logic [8:0] r;
    logic [7:0] q;
    r = {1'b0, rem_q};
    q = quo_q;
    for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
      r = {r[7:0], q[7]};
      q = {q[6:0], 1'b0};
      if (r >= {1'b0, div_q}) begin
        r    = r - {1'b0, div_q};
        q[0] = 1'b1;
      end
    end
    rem_d = r[7:0];
    quo_d = q;
  end

  assign prod = {8'b0, quo_d} * {8'b0, cfg_i.min_insn_len};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= 1'b0;
      pend_q  <= 1'b0;
      ent_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      div_q   <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            ent_q <= ent_c;
            if (need_div) begin
              state_q <= F_DIV;
              step_q  <= 1'b0;
              pend_q  <= 1'b0;
              quo_q   <= adj_c;
              rem_q   <= 8'd0;
              div_q   <= div_c;
            end else begin
              pend_q <= 1'b1;
            end
          end else if (push_ready_i) begin
            pend_q <= 1'b0;
          end
        end
        F_DIV: begin
          rem_q  <= rem_d;
          quo_q  <= quo_d;
          step_q <= 1'b1;
          if (step_q) begin
            ent_q.addr_val <= {48'b0, prod};
            ent_q.ldelta   <= {{24{cfg_i.ln_base[7]}}, cfg_i.ln_base}
                              + $signed({24'b0, rem_d});
            pend_q  <= 1'b1;
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/lnp_fifo.sv]
module lnp_fifo import lnp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  output logic   push_ready_o,
  input  entry_t data_i,
  input  logic   pop_i,
  output logic   not_empty_o,
  output entry_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != (PTR_W+1)'(DEPTH));
  assign not_empty_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && not_empty_o;
  assign data_o       = mem_q[rd_q];

  function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= inc_ptr(wr_q);
      if (do_pop)  rd_q <= inc_ptr(rd_q);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/lnp_back.sv]
module lnp_back import lnp_pkg::*; #(
  parameter int unsigned AW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          not_empty_i,
  input  entry_t        entry_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [AW-1:0] row_address_o,
  output logic [31:0]   row_file_o,
  output logic [31:0]   row_line_o,
  output logic          end_of_sequence_o,
  output err_e          error_code_o
);

  logic [AW-1:0] addr_q, addr_d;
  logic [31:0]   line_q, line_d;
  logic [31:0]   file_q, file_d;
  logic          stmt_q, stmt_d;

  logic          out_valid_q;
  logic [AW-1:0] o_addr_q, o_addr_d;
  logic [31:0]   o_file_q;
  logic [31:0]   o_line_q, o_line_d;
  logic          o_eos_q, o_eos_d;
  err_e          o_err_q, o_err_d;

  logic          emit;
  logic          row_ok;
  logic [AW-1:0] addr_sum;
  logic [33:0]   line_sum;
  logic          underflow;

  assign pop_o    = not_empty_i && (!out_valid_q || out_ready_i);
  assign row_ok   = stmt_q && (file_q[31:16] == 16'd0) && (file_q[15:0] < cfg_i.file_count);
  assign addr_sum = addr_q + entry_i.addr_val[AW-1:0];
  // Line plus signed delta; a set sign bit means the line would go below zero.
  assign line_sum  = {2'b0, line_q} + {{2{entry_i.ldelta[31]}}, entry_i.ldelta};
  assign underflow = line_sum[33];

  always_comb begin
    addr_d   = addr_q;
    line_d   = line_q;
    file_d   = file_q;
    stmt_d   = stmt_q;
    emit     = 1'b0;
    o_addr_d = addr_q;
    o_line_d = line_q;
    o_eos_d  = 1'b0;
    o_err_d  = ERR_NONE;
    unique case (entry_i.kind)
      K_COPY:     emit = row_ok;
      K_ADV_ADDR: addr_d = addr_sum;
      K_ADV_LINE: begin
        if (underflow) begin
          emit    = 1'b1;
          o_err_d = ERR_UNDERFLOW;
        end else begin
          line_d = line_sum[31:0];
        end
      end
      K_SET_FILE: file_d = entry_i.file;
      K_NEG_STMT: stmt_d = !stmt_q;
      K_SPECIAL: begin
        addr_d   = addr_sum;
        o_addr_d = addr_sum;
        if (underflow) begin
          emit    = 1'b1;
          o_err_d = ERR_UNDERFLOW;
        end else begin
          line_d   = line_sum[31:0];
          o_line_d = line_sum[31:0];
          emit     = row_ok;
        end
      end
      K_END_SEQ: begin
        emit    = row_ok;
        o_eos_d = 1'b1;
        addr_d  = '0;
        line_d  = 32'd1;
        file_d  = 32'd1;
        stmt_d  = cfg_i.default_stmt;
      end
      K_SET_ADDR: addr_d = entry_i.addr_val[AW-1:0];
      K_BAD_OP: begin
        emit    = 1'b1;
        o_err_d = ERR_UNKNOWN;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      line_q      <= 32'd1;
      file_q      <= 32'd1;
      stmt_q      <= RST_DEFAULT_STMT;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        addr_q <= addr_d;
        line_q <= line_d;
        file_q <= file_d;
        stmt_q <= stmt_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      o_addr_q <= o_addr_d;
      o_file_q <= file_q;
      o_line_q <= o_line_d;
      o_eos_q  <= o_eos_d;
      o_err_q  <= o_err_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign row_address_o     = o_addr_q;
  assign row_file_o        = o_file_q;
  assign row_line_o        = o_line_q;
  assign end_of_sequence_o = o_eos_q;
  assign error_code_o      = o_err_q;

endmodule

[rtl/line_number_program_engine.sv]
// Line-table register engine for decoded line-program instructions.
// The slave stream carries one instruction per word: cmd and the extended
// opcode in tuser, operand and line advance in tdata. The master stream
// returns at most one word per instruction: the row's address, file and line
// in tdata, the error code in tuser and tlast set on the row written by end
// sequence. The configuration channel writes one of six registers per
// handshake; it is always ready and is meant to be written while the engine
// is idle.
// Simple instructions are taken one per cycle while the queue has room. A
// special opcode or const add pc holds the input while the divider splits
// the adjusted opcode by the line range four bits per cycle.
// A result word passes the front register, the queue and the output
// register; an instruction that divides passes the divider first.
// A small queue sits between decode and execution, so the input keeps
// flowing while a result waits in the output register; when the receiver
// stalls and the queue fills, s_axis_tready drops.
// Reset clears the queue and output and loads the default configuration
// and the initial line-table registers.
module line_number_program_engine import lnp_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 64,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [95:0]           s_axis_tdata,  // operand[63:0], ln_adv[95:64]
  input  logic [15:0]           s_axis_tuser,  // cmd[7:0], ext_op[15:8]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // row_address, row_file, row_line, zero fill to whole bytes
  output logic [((ADDRESS_BITS+64+7)/8)*8-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser,  // error_code[1:0]
  output logic                  m_axis_tlast   // end_of_sequence
);

  localparam int unsigned AW = ADDRESS_BITS;

  cfg_t   cfg_q;
  logic   push, push_ready, pop, not_empty;
  entry_t fe_entry, q_entry;

  logic [AW-1:0] row_address;
  logic [31:0]   row_file, row_line;
  logic          eos;
  err_e          err;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.op_base      <= RST_OP_BASE;
      cfg_q.ln_range     <= RST_LN_RANGE;
      cfg_q.ln_base      <= RST_LN_BASE;
      cfg_q.min_insn_len <= RST_MIN_INSN_LEN;
      cfg_q.default_stmt <= RST_DEFAULT_STMT;
      cfg_q.file_count   <= RST_FILE_COUNT;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_OP_BASE:      cfg_q.op_base      <= cfg_data_i[3:0];
        CFG_LN_RANGE:     cfg_q.ln_range     <= cfg_data_i[7:0];
        CFG_LN_BASE:      cfg_q.ln_base      <= cfg_data_i[7:0];
        CFG_MIN_INSN_LEN: cfg_q.min_insn_len <= cfg_data_i[7:0];
        CFG_DEFAULT_STMT: cfg_q.default_stmt <= cfg_data_i[0];
        CFG_FILE_COUNT:   cfg_q.file_count   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lnp_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser[7:0]),
    .ext_op_i     (s_axis_tuser[15:8]),
    .operand_i    (s_axis_tdata[63:0]),
    .ln_adv_i     (s_axis_tdata[95:64]),
    .push_o       (push),
    .push_ready_i (push_ready),
    .entry_o      (fe_entry)
  );

  lnp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_ready_o (push_ready),
    .data_i       (fe_entry),
    .pop_i        (pop),
    .not_empty_o  (not_empty),
    .data_o       (q_entry)
  );

  lnp_back #(.AW(AW)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i             (cfg_q),
    .not_empty_i       (not_empty),
    .entry_i           (q_entry),
    .pop_o             (pop),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .row_address_o     (row_address),
    .row_file_o        (row_file),
    .row_line_o        (row_line),
    .end_of_sequence_o (eos),
    .error_code_o      (err)
  );

  always_comb begin
    m_axis_tdata          = '0;
    m_axis_tdata[AW+63:0] = {row_line, row_file, row_address};
  end

  assign m_axis_tuser = err;
  assign m_axis_tlast = eos;

  // The end-of-sequence row is always a real row, never an error word.
  a_eos_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == ERR_NONE)
    else $error("end-of-sequence word carries an error code");

  // The back end never pops while its output word is stalled.
  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !pop)
    else $error("queue popped while result is stalled");

  // The front holds its word until the queue takes it.
  a_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !push_ready |=> push && $stable(fe_entry))
    else $error("front dropped a word the queue refused");

  // The input is ready only while the front holds no word or the queue takes it.
  a_accept_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !push || push_ready)
    else $error("input accepted while the front word is blocked");

endmodule
